// ===== src/mbfr_pkg.sv =====
// Shared types and constants for the MSB-first bit field reader.
`timescale 1ns / 1ps

package mbfr_pkg;

    localparam int FIELD_W = 32;
    localparam int BYTE_W  = 8;
    localparam int CMD_W   = 2;
    localparam int WIDTH_W = 6;
    localparam int HELD_W  = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_FEED   = 2'd0,
        CMD_READ_U = 2'd1,
        CMD_READ_S = 2'd2,
        CMD_ALIGN  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic                is_feed;
        logic                is_read;
        logic                is_align;
        logic [BYTE_W-1:0]   byte_in;
        logic [WIDTH_W-1:0]  width;
        logic [FIELD_W-1:0]  ext_mask;
    } t_op;

    typedef struct packed {
        logic [FIELD_W-1:0]  field_value;
        t_status             status;
        logic [HELD_W-1:0]   bits_held;
    } t_res;

endpackage

// ===== src/mbfr_fifo.sv =====
// Two-entry queue of words with independent push and pop.
`timescale 1ns / 1ps

module mbfr_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== src/mbfr_front.sv =====
// Front decode: command classification, width saturation and sign mask.
`timescale 1ns / 1ps

module mbfr_front #(
    parameter int MAX_FIELD_BITS = 32
) (
    input  logic [mbfr_pkg::CMD_W-1:0]   i_cmd,
    input  logic [mbfr_pkg::BYTE_W-1:0]  i_byte_in,
    input  logic [mbfr_pkg::WIDTH_W-1:0] i_field_width,
    output mbfr_pkg::t_op                o_op
);

    logic [mbfr_pkg::WIDTH_W-1:0] w_sat;
    logic                         is_signed;

    always_comb begin
        if (32'(i_field_width) > 32'(MAX_FIELD_BITS)) begin
            w_sat = mbfr_pkg::WIDTH_W'(MAX_FIELD_BITS);
        end else begin
            w_sat = i_field_width;
        end
    end

    always_comb begin
        o_op.is_feed  = 1'b0;
        o_op.is_read  = 1'b0;
        o_op.is_align = 1'b0;
        is_signed     = 1'b0;
        unique case (mbfr_pkg::t_cmd'(i_cmd))
            mbfr_pkg::CMD_FEED: begin
                o_op.is_feed = 1'b1;
            end
            mbfr_pkg::CMD_READ_U: begin
                o_op.is_read = 1'b1;
            end
            mbfr_pkg::CMD_READ_S: begin
                o_op.is_read = 1'b1;
                is_signed    = 1'b1;
            end
            mbfr_pkg::CMD_ALIGN: begin
                o_op.is_align = 1'b1;
            end
            default: begin
                o_op.is_align = 1'b0;
            end
        endcase
        o_op.byte_in = i_byte_in;
        o_op.width   = w_sat;
        if (is_signed && (w_sat != '0)
                && (32'(w_sat) < 32'(mbfr_pkg::FIELD_W))) begin
            o_op.ext_mask = {mbfr_pkg::FIELD_W{1'b1}} << w_sat;
        end else begin
            o_op.ext_mask = '0;
        end
    end

endmodule

// ===== src/mbfr_back.sv =====
// Back execution: bit buffer state, field extraction and result build.
`timescale 1ns / 1ps

module mbfr_back #(
    parameter int BUFFER_BITS = 40
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_op_valid,
    input  mbfr_pkg::t_op i_op,
    output logic          o_op_take,
    input  logic          i_res_ready,
    output mbfr_pkg::t_res o_res
);

    localparam int CW   = $clog2(BUFFER_BITS + 1);
    localparam int IW   = $clog2(BUFFER_BITS);
    localparam int CMPW = (CW > mbfr_pkg::WIDTH_W) ? CW : mbfr_pkg::WIDTH_W;

    logic [BUFFER_BITS-1:0]     r_buf;
    logic [BUFFER_BITS-1:0]     n_buf;
    logic [CW-1:0]              r_held;
    logic [CW-1:0]              n_held;
    logic                       fire;
    logic                       feed_full;
    logic                       read_short;
    logic [CMPW-1:0]            rest_wide;
    logic [CW-1:0]              rest;
    logic [BUFFER_BITS-1:0]     wmask;
    logic [BUFFER_BITS-1:0]     value_full;
    logic [mbfr_pkg::FIELD_W-1:0] value32;
    logic                       sign_bit;
    logic [IW-1:0]              top_idx;

    assign fire      = i_op_valid && i_res_ready;
    assign o_op_take = fire;

    assign feed_full  = ((CW + 1)'(r_held) + (CW + 1)'(mbfr_pkg::BYTE_W))
                        > (CW + 1)'(BUFFER_BITS);
    assign read_short = CMPW'(i_op.width) > CMPW'(r_held);
    assign rest_wide  = CMPW'(r_held) - CMPW'(i_op.width);
    assign rest       = CW'(rest_wide);
    assign wmask      = ~({BUFFER_BITS{1'b1}} << i_op.width);
    assign value_full = (r_buf >> rest) & wmask;
    assign top_idx    = IW'(r_held - CW'(1));
    assign sign_bit   = (r_held != '0) ? r_buf[top_idx] : 1'b0;

    always_comb begin
        value32 = mbfr_pkg::FIELD_W'(value_full);
        if (sign_bit) begin
            value32 = value32 | i_op.ext_mask;
        end
    end

    always_comb begin
        n_buf             = r_buf;
        n_held            = r_held;
        o_res.field_value = '0;
        o_res.status      = mbfr_pkg::ST_OK;
        if (i_op.is_feed) begin
            if (feed_full) begin
                o_res.status = mbfr_pkg::ST_FULL;
            end else begin
                n_buf  = {r_buf[BUFFER_BITS-mbfr_pkg::BYTE_W-1:0], i_op.byte_in};
                n_held = r_held + CW'(mbfr_pkg::BYTE_W);
            end
        end else if (i_op.is_align) begin
            n_held = {r_held[CW-1:3], 3'b000};
        end else if (i_op.is_read) begin
            if (read_short) begin
                o_res.status = mbfr_pkg::ST_SHORT;
            end else begin
                n_held            = rest;
                o_res.field_value = value32;
            end
        end
        o_res.bits_held = mbfr_pkg::HELD_W'(n_held);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf  <= '0;
            r_held <= '0;
        end else if (fire) begin
            r_buf  <= n_buf;
            r_held <= n_held;
        end
    end

`ifndef NO_ASSERTIONS
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_held) <= BUFFER_BITS)
        else $error("bit count above buffer size");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> $stable(r_held) && $stable(r_buf))
        else $error("buffer state moved without an operation");

    a_feed_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && i_op.is_feed && !feed_full |=> r_held == $past(r_held) + CW'(8))
        else $error("feed did not add one byte");

    a_align_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && i_op.is_align |=> r_held[2:0] == 3'b000)
        else $error("align left a partial byte");
`endif

endmodule

// ===== src/msb_first_bit_field_reader.sv =====
// Top level of the MSB-first variable-width bit field reader.
`timescale 1ns / 1ps

// Each word is a feed of one byte, an unsigned or signed read of 0 to 32 bits
// taken most-significant first, or an align that drops the rest of a partly
// used byte; every word yields exactly one result word with value, status and
// the count of bits still held. The block takes one word per cycle while full
// is low: a decode stage writes into a two-word queue, the execute unit does one
// barrel shift of the bit buffer per cycle unless stalled, and results wait in a
// second two-word queue: a word is registered in the first, its result in the
// second. full and empty stall each side on its own.
module msb_first_bit_field_reader #(
    parameter int MAX_FIELD_BITS = 32,
    parameter int BUFFER_BITS    = 40
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [mbfr_pkg::CMD_W-1:0]    i_cmd,
    input  logic [mbfr_pkg::BYTE_W-1:0]   i_byte_in,
    input  logic [mbfr_pkg::WIDTH_W-1:0]  i_field_width,
    input  logic                          pop,
    output logic                          empty,
    output logic [mbfr_pkg::FIELD_W-1:0]  o_field_value,
    output logic [1:0]                    o_status,
    output logic [mbfr_pkg::HELD_W-1:0]   o_bits_held
);

    mbfr_pkg::t_op  dec_op;
    mbfr_pkg::t_op  q_op;
    mbfr_pkg::t_res exe_res;
    mbfr_pkg::t_res q_res;
    logic           op_empty;
    logic           op_take;
    logic           res_full;

    mbfr_front #(
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) u_front (
        .i_cmd          (i_cmd),
        .i_byte_in      (i_byte_in),
        .i_field_width  (i_field_width),
        .o_op           (dec_op)
    );

    mbfr_fifo #(
        .WIDTH   ($bits(mbfr_pkg::t_op))
    ) u_op_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (dec_op),
        .o_full  (full),
        .i_pop   (op_take),
        .o_data  (q_op),
        .o_empty (op_empty)
    );

    mbfr_back #(
        .BUFFER_BITS (BUFFER_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (!op_empty),
        .i_op        (q_op),
        .o_op_take   (op_take),
        .i_res_ready (!res_full),
        .o_res       (exe_res)
    );

    mbfr_fifo #(
        .WIDTH   ($bits(mbfr_pkg::t_res))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_take),
        .i_data  (exe_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (q_res),
        .o_empty (empty)
    );

    assign o_field_value = q_res.field_value;
    assign o_status      = q_res.status;
    assign o_bits_held   = q_res.bits_held;

endmodule
